// ===== hdl/cbl_pkg.sv =====
// Package for the centered alpha blit: item types, register map and reset values.
// Also holds the per-channel blend function. Depends on nothing.
package cbl_pkg;

  // Default for the largest supported image or window dimension
  localparam int MaxDimDefault = 1024;

  // Configuration port geometry: five registers at a 4-byte stride
  localparam int AddrW = 5;
  localparam int DataW = 32;
  localparam int SizeW = 11;
  localparam int RgbW  = 24;

  // Register reset values
  localparam logic [SizeW-1:0] SizeReset = 11'd1;
  localparam logic [RgbW-1:0]  BgReset   = 24'h202020;

  // Alpha code that passes the source color through untouched
  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] AlphaClear  = 8'h00;

  // Register indexes, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_WINDOW_WIDTH  = 3'd2,
    REG_WINDOW_HEIGHT = 3'd3,
    REG_BACKGROUND    = 3'd4
  } reg_idx_e;

  // Input item: one RGBA pixel
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_t;

  // Result item: placed and blended pixel
  typedef struct packed {
    logic       draw;
    logic [9:0] dest_x;
    logic [9:0] dest_y;
    logic [23:0] color_out;
    logic       frame_last;
  } res_t;

  // Blend one channel: (c*a + bg*(255-a)) / 255, truncated.
  // Divide by 255 as (n + (n >> 8) + 1) >> 8, exact for every n up to 255*255, the largest sum.
  function automatic logic [7:0] blend_ch(input logic [7:0] c, input logic [7:0] a,
                                          input logic [7:0] bg);
    logic [15:0] num;
    logic [15:0] adj;
    num = 16'(c) * 16'(a) + 16'(bg) * 16'(AlphaOpaque - a);
    adj = num + 16'(num[15:8]) + 16'd1;
    return adj[15:8];
  endfunction

endpackage

// ===== hdl/cbl_cfg.sv =====
// Configuration register file for the centered alpha blit, APB-style write/read.
// Clamps the size register outputs to 1..MAX_DIM. Depends on cbl_pkg.
module cbl_cfg #(
  parameter int MAX_DIM = cbl_pkg::MaxDimDefault,
  localparam int DimW = $clog2(MAX_DIM + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cbl_pkg::AddrW-1:0]  paddr,
  input  logic [cbl_pkg::DataW-1:0]  pwdata,
  output logic [cbl_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output logic [DimW-1:0]            img_w_o,
  output logic [DimW-1:0]            img_h_o,
  output logic [DimW-1:0]            win_w_o,
  output logic [DimW-1:0]            win_h_o,
  output logic [cbl_pkg::RgbW-1:0]   bg_o
);
  import cbl_pkg::*;

  logic [SizeW-1:0] img_w_q, img_h_q, win_w_q, win_h_q;
  logic [RgbW-1:0]  bg_q;
  logic             wr_en;
  reg_idx_e         idx;

  // Map a raw size register into 1..MAX_DIM
  function automatic logic [DimW-1:0] clamp_dim(input logic [SizeW-1:0] raw);
    logic [DimW-1:0] res;
    if (raw == '0) begin
      res = DimW'(1);
    end else if (32'(raw) > 32'(MAX_DIM)) begin
      res = DimW'(MAX_DIM);
    end else begin
      res = DimW'(raw);
    end
    return res;
  endfunction

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= SizeReset;
      img_h_q <= SizeReset;
      win_w_q <= SizeReset;
      win_h_q <= SizeReset;
      bg_q    <= BgReset;
    end else if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:   img_w_q <= pwdata[SizeW-1:0];
        REG_IMAGE_HEIGHT:  img_h_q <= pwdata[SizeW-1:0];
        REG_WINDOW_WIDTH:  win_w_q <= pwdata[SizeW-1:0];
        REG_WINDOW_HEIGHT: win_h_q <= pwdata[SizeW-1:0];
        REG_BACKGROUND:    bg_q    <= pwdata[RgbW-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero beyond the map
  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:   prdata = DataW'(img_w_q);
      REG_IMAGE_HEIGHT:  prdata = DataW'(img_h_q);
      REG_WINDOW_WIDTH:  prdata = DataW'(win_w_q);
      REG_WINDOW_HEIGHT: prdata = DataW'(win_h_q);
      REG_BACKGROUND:    prdata = DataW'(bg_q);
      default:           prdata = '0;
    endcase
  end

  assign img_w_o = clamp_dim(img_w_q);
  assign img_h_o = clamp_dim(img_h_q);
  assign win_w_o = clamp_dim(win_w_q);
  assign win_h_o = clamp_dim(win_h_q);
  assign bg_o    = bg_q;

endmodule

// ===== hdl/cbl_scan.sv =====
// Input stage of the centered alpha blit: input register plus raster counters.
// Tags each accepted pixel with its column, row and end-of-frame flag. Depends on cbl_pkg.
module cbl_scan #(
  parameter int MAX_DIM = cbl_pkg::MaxDimDefault,
  localparam int DimW = $clog2(MAX_DIM + 1),
  localparam int CntW = $clog2(MAX_DIM)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  cbl_pkg::pix_t        in_data_i,
  output logic                 in_stall_o,
  input  logic [DimW-1:0]      img_w_i,
  input  logic [DimW-1:0]      img_h_i,
  input  logic                 next_ready_i,
  output logic                 valid_o,
  output cbl_pkg::pix_t        pix_o,
  output logic [CntW-1:0]      col_o,
  output logic [CntW-1:0]      row_o,
  output logic                 last_o
);
  import cbl_pkg::*;

  logic            valid_q, valid_d;
  pix_t            pix_q;
  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [CntW-1:0] s_col_q, s_row_q;
  logic            last_q;
  logic            accept;
  logic            end_row, end_frame;

  assign in_stall_o = valid_q && !next_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // A counter at or past the last index wraps
  assign end_row   = DimW'(col_q) >= (img_w_i - DimW'(1));
  assign end_frame = DimW'(row_q) >= (img_h_i - DimW'(1));

  // Advance the raster position on each accepted item
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_frame ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  // Hold the stage while the result stage is full
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (next_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      valid_q <= valid_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // Capture the pixel with its position
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q   <= in_data_i;
      s_col_q <= col_q;
      s_row_q <= row_q;
      last_q  <= end_row && end_frame;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign col_o   = s_col_q;
  assign row_o   = s_row_q;
  assign last_o  = last_q;

endmodule

// ===== hdl/cbl_shade.sv =====
// Result stage of the centered alpha blit: centering, clipping, blend, result register.
// Depends on cbl_pkg for the item types and the channel blend.
module cbl_shade #(
  parameter int MAX_DIM = cbl_pkg::MaxDimDefault,
  localparam int DimW = $clog2(MAX_DIM + 1),
  localparam int CntW = $clog2(MAX_DIM)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  cbl_pkg::pix_t             pix_i,
  input  logic [CntW-1:0]           col_i,
  input  logic [CntW-1:0]           row_i,
  input  logic                      last_i,
  output logic                      ready_o,
  input  logic [DimW-1:0]           img_w_i,
  input  logic [DimW-1:0]           img_h_i,
  input  logic [DimW-1:0]           win_w_i,
  input  logic [DimW-1:0]           win_h_i,
  input  logic [cbl_pkg::RgbW-1:0]  bg_i,
  output logic                      out_valid_o,
  output cbl_pkg::res_t             out_data_o,
  input  logic                      out_stall_i
);
  import cbl_pkg::*;

  logic signed [DimW:0]   diff_x, diff_y, off_x, off_y;
  logic signed [DimW+1:0] dx, dy;
  logic                   in_x, in_y, draw;
  logic [RgbW-1:0]        mix_rgb;
  res_t                   res_d, res_q;
  logic                   valid_q, valid_d;
  logic                   load;

  // Offset is (window - image) / 2, truncated toward zero
  assign diff_x = $signed({1'b0, win_w_i}) - $signed({1'b0, img_w_i});
  assign diff_y = $signed({1'b0, win_h_i}) - $signed({1'b0, img_h_i});
  assign off_x  = (diff_x + $signed({{DimW{1'b0}}, diff_x[DimW]})) >>> 1;
  assign off_y  = (diff_y + $signed({{DimW{1'b0}}, diff_y[DimW]})) >>> 1;

  // Window position and clip test
  assign dx   = (DimW+2)'(off_x) + $signed((DimW+2)'(col_i));
  assign dy   = (DimW+2)'(off_y) + $signed((DimW+2)'(row_i));
  assign in_x = !dx[DimW+1] && (dx < $signed((DimW+2)'(win_w_i)));
  assign in_y = !dy[DimW+1] && (dy < $signed((DimW+2)'(win_h_i)));
  assign draw = in_x && in_y && (pix_i.alpha_in != AlphaClear);

  // Blend each channel over the background
  assign mix_rgb = {blend_ch(pix_i.red_in,   pix_i.alpha_in, bg_i[23:16]),
                    blend_ch(pix_i.green_in, pix_i.alpha_in, bg_i[15:8]),
                    blend_ch(pix_i.blue_in,  pix_i.alpha_in, bg_i[7:0])};

  // Build the result; drop coordinates and color when not drawn
  always_comb begin
    res_d            = '0;
    res_d.frame_last = last_i;
    if (draw) begin
      res_d.draw   = 1'b1;
      res_d.dest_x = 10'(dx);
      res_d.dest_y = 10'(dy);
      if (pix_i.alpha_in == AlphaOpaque) begin
        res_d.color_out = {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
      end else begin
        res_d.color_out = mix_rgb;
      end
    end
  end

  assign ready_o = !valid_q || !out_stall_i;
  assign load    = valid_i && ready_o;

  // Hold a stalled result, clear a taken one
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

// ===== hdl/centered_alpha_blit_core.sv =====
// Top level of the centered alpha blit: config registers, input stage, result stage.
// Depends on cbl_pkg, cbl_cfg, cbl_scan and cbl_shade.
//
// Takes RGBA pixels in raster order, one item per clock while in_stall_o is
// low, and gives one result item per pixel. Each item passes the input
// register (which also keeps the raster column and row counters) and then the
// result register; between them sit the centering adders, the clip compares
// and the two 8x8 blend multiplies per channel. A stalled output backs up
// through both registers, so up to two items are held inside. The image is
// centered in the window with offset (window - image) / 2 truncated toward
// zero; size registers of 0 act as 1 and values above MAX_DIM act as MAX_DIM.
// Write registers only while idle.
module centered_alpha_blit_core #(
  parameter int MAX_DIM = cbl_pkg::MaxDimDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  cbl_pkg::pix_t              in_data_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  output cbl_pkg::res_t              out_data_o,
  input  logic                       out_stall_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cbl_pkg::AddrW-1:0]  paddr,
  input  logic [cbl_pkg::DataW-1:0]  pwdata,
  output logic [cbl_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import cbl_pkg::*;

  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int CntW = $clog2(MAX_DIM);

  logic [DimW-1:0] img_w, img_h, win_w, win_h;
  logic [RgbW-1:0] bg;
  logic            s1_valid, s2_ready, s1_last;
  pix_t            s1_pix;
  logic [CntW-1:0] s1_col, s1_row;

  cbl_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .img_w_o (img_w),
    .img_h_o (img_h),
    .win_w_o (win_w),
    .win_h_o (win_h),
    .bg_o    (bg)
  );

  cbl_scan #(.MAX_DIM(MAX_DIM)) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .img_w_i      (img_w),
    .img_h_i      (img_h),
    .next_ready_i (s2_ready),
    .valid_o      (s1_valid),
    .pix_o        (s1_pix),
    .col_o        (s1_col),
    .row_o        (s1_row),
    .last_o       (s1_last)
  );

  cbl_shade #(.MAX_DIM(MAX_DIM)) u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .pix_i       (s1_pix),
    .col_i       (s1_col),
    .row_i       (s1_row),
    .last_i      (s1_last),
    .ready_o     (s2_ready),
    .img_w_i     (img_w),
    .img_h_i     (img_h),
    .win_w_i     (win_w),
    .win_h_i     (win_h),
    .bg_i        (bg),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== hdl/cbl_checker.sv =====
// Port-level checker for the centered alpha blit, bound to the top level.
// Depends on cbl_pkg and on centered_alpha_blit_core.
module cbl_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input cbl_pkg::res_t out_data_o,
  input logic          out_stall_i
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed");

  // An accepted item leads to a valid output once it has passed both registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("accepted item did not reach the output");

  // Stall the input only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with the output register empty");

  // An undrawn item carries no position and no color
  a_undrawn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.draw |->
      out_data_o.dest_x == '0 && out_data_o.dest_y == '0 && out_data_o.color_out == '0)
    else $error("undrawn item has nonzero fields");

endmodule

bind centered_alpha_blit_core cbl_checker u_cbl_checker (.*);

// ===== dv/centered_alpha_blit_core_tb.sv =====
// Testbench for centered_alpha_blit_core: directed table, then random pixel phases
// checked against a placement and blend predictor. Depends on cbl_pkg and the core RTL.
module centered_alpha_blit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbl_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int PipeDepth   = 2;
  localparam int RandomItems = 1530;
  localparam int LongHold    = 200;
  localparam int HoldAfter   = 400;
  localparam int CycleLimit  = 400000;

  typedef enum bit {
    STEP_PIXEL,
    STEP_WRITE
  } step_kind_e;

  typedef struct {
    step_kind_e kind;
    reg_idx_e   idx;
    logic [31:0] value;
    pix_t       pix;
    bit         typed;
    res_t       want;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  pix_t in_data_i;
  logic in_stall_o;
  logic out_valid_o;
  res_t out_data_o;
  logic out_stall_i;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  // Predictor state: register copies and raster position
  logic [SizeW-1:0] size_reg [4];
  logic [RgbW-1:0]  bg_rgb;
  int col_at;
  int row_at;

  res_t  placed_q[$];
  step_t plan[$];
  int    mismatches;
  int    results_seen;
  int    cycle_count;
  bit    brisk;
  bit    held_long;

  centered_alpha_blit_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Clamp a size register the way the block reads it
  function automatic int eff_dim(logic [SizeW-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MaxDimDefault) return MaxDimDefault;
    return int'(v);
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] c, logic [7:0] a, logic [7:0] bg);
    int n;
    n = int'(c) * int'(a) + int'(bg) * (int'(AlphaOpaque) - int'(a));
    return 8'(n / int'(AlphaOpaque));
  endfunction

  // Place one pixel in the window, blend it, and advance the raster position
  function automatic res_t place_pixel(pix_t p);
    int iw, ih, ww, wh, dx, dy;
    logic end_row, end_frame;
    res_t r;
    iw = eff_dim(size_reg[REG_IMAGE_WIDTH]);
    ih = eff_dim(size_reg[REG_IMAGE_HEIGHT]);
    ww = eff_dim(size_reg[REG_WINDOW_WIDTH]);
    wh = eff_dim(size_reg[REG_WINDOW_HEIGHT]);
    dx = (ww - iw) / 2 + col_at;
    dy = (wh - ih) / 2 + row_at;
    end_row = col_at >= iw - 1;
    end_frame = row_at >= ih - 1;
    r = '0;
    if (dx >= 0 && dx < ww && dy >= 0 && dy < wh && p.alpha_in != AlphaClear) begin
      r.draw = 1'b1;
      r.dest_x = dx[9:0];
      r.dest_y = dy[9:0];
      if (p.alpha_in == AlphaOpaque) begin
        r.color_out = {p.red_in, p.green_in, p.blue_in};
      end else begin
        r.color_out = {mix_channel(p.red_in, p.alpha_in, bg_rgb[23:16]),
                       mix_channel(p.green_in, p.alpha_in, bg_rgb[15:8]),
                       mix_channel(p.blue_in, p.alpha_in, bg_rgb[7:0])};
      end
    end
    r.frame_last = end_row && end_frame;
    if (end_row) begin
      col_at = 0;
      row_at = end_frame ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
    return r;
  endfunction

  function automatic logic [SizeW-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SizeW'(MaxDimDefault);
      3: return SizeW'($urandom_range(1, 2047));
      4: return SizeW'(1);
      default: return SizeW'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic void plan_write(reg_idx_e idx, logic [31:0] value);
    plan.push_back('{STEP_WRITE, idx, value, '0, 1'b0, '0});
  endfunction

  function automatic void plan_pixel(logic [31:0] pix, bit typed, res_t want);
    plan.push_back('{STEP_PIXEL, REG_IMAGE_WIDTH, '0, pix_t'(pix), typed, want});
  endfunction

  // Write a register through setup and access cycles, then read it back
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    logic [DataW-1:0] back;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= value;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    back = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    // Leave the bus idle so a following access starts on a fresh edge
    @(posedge clk_i);
    if (back !== value) begin
      $display("%0t: readback of %s: expected %h, got %h", $time, idx.name(), value, back);
      mismatches++;
    end
    if (idx == REG_BACKGROUND) bg_rgb = value[RgbW-1:0];
    else size_reg[int'(idx)] = value[SizeW-1:0];
  endtask

  // Offer one pixel after a random gap and hold it until accepted
  task automatic send_pixel(pix_t p, bit typed, res_t want);
    int gap;
    bit fire;
    res_t guess;
    gap = brisk ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do begin
      @(negedge clk_i);
      fire = !in_stall_o;
      @(posedge clk_i);
    end while (!fire);
    guess = place_pixel(p);
    placed_q.push_back(typed ? want : guess);
  endtask

  // Drain the pipeline before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (placed_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    mismatches++;
  endtask

  // Result side: random stalls, one long hold, compare with the oldest expectation
  initial begin : result_side
    int pause;
    bit fire;
    res_t got;
    res_t want;
    out_stall_i = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      pause = brisk ? 0 : $urandom_range(0, 15);
      if (!held_long && results_seen >= HoldAfter) begin
        pause = LongHold;
        held_long = 1'b1;
      end
      if (pause > 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        fire = out_valid_o;
        got = out_data_o;
        @(posedge clk_i);
      end while (!fire);
      results_seen++;
      if (placed_q.size() == 0) begin
        $display("%0t: result with nothing pending: %p", $time, got);
        mismatches++;
      end else begin
        want = placed_q.pop_front();
        if (got.draw !== want.draw) note_mismatch("draw", want.draw, got.draw);
        if (got.dest_x !== want.dest_x) note_mismatch("dest_x", want.dest_x, got.dest_x);
        if (got.dest_y !== want.dest_y) note_mismatch("dest_y", want.dest_y, got.dest_y);
        if (got.color_out !== want.color_out)
          note_mismatch("color_out", want.color_out, got.color_out);
        if (got.frame_last !== want.frame_last)
          note_mismatch("frame_last", want.frame_last, got.frame_last);
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain, verdict
  initial begin : pixel_side
    int sent;
    int n;
    bit first;
    pix_t p;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < 4; i++) size_reg[i] = SizeReset;
    bg_rgb = BgReset;
    col_at = 0;
    row_at = 0;
    mismatches = 0;
    results_seen = 0;
    cycle_count = 0;
    brisk = 1'b0;
    held_long = 1'b0;

    // Result fields in order: draw, dest_x, dest_y, color_out, frame_last.
    // Reset sizes: 1x1 image in a 1x1 window, every pixel ends the frame.
    plan_pixel(32'hFFFFFFFF, 1, res_t'({1'b1, 10'd0, 10'd0, 24'hFFFFFF, 1'b1}));
    plan_pixel(32'h000000FF, 1, res_t'({1'b1, 10'd0, 10'd0, 24'h000000, 1'b1}));
    plan_pixel(32'h12345600, 1, res_t'({1'b0, 10'd0, 10'd0, 24'h000000, 1'b1}));
    plan_pixel(32'hFF00FF80, 0, '0);
    plan_pixel(32'h00FF0001, 0, '0);
    plan_pixel(32'hAA55AAFE, 0, '0);
    // Blend over black and over white
    plan_write(REG_BACKGROUND, 32'h000000);
    plan_pixel(32'h8040C07F, 0, '0);
    plan_write(REG_BACKGROUND, 32'hFFFFFF);
    plan_pixel(32'h0000007F, 0, '0);
    plan_pixel(32'hFFFFFF01, 0, '0);
    // 3x2 image in 1x1 window: negative x offset, y offset truncates to zero
    plan_write(REG_IMAGE_WIDTH, 32'd3);
    plan_write(REG_IMAGE_HEIGHT, 32'd2);
    plan_pixel(32'h112233FF, 1, res_t'({1'b0, 10'd0, 10'd0, 24'h000000, 1'b0}));
    plan_pixel(32'h445566FF, 1, res_t'({1'b1, 10'd0, 10'd0, 24'h445566, 1'b0}));
    plan_pixel(32'h778899FF, 1, res_t'({1'b0, 10'd0, 10'd0, 24'h000000, 1'b0}));
    plan_pixel(32'hAABBCCFF, 1, res_t'({1'b0, 10'd0, 10'd0, 24'h000000, 1'b0}));
    // Shrink width mid-frame, zero width acts as one: row and frame end at once
    plan_write(REG_IMAGE_WIDTH, 32'd0);
    plan_pixel(32'h13579BFF, 1, res_t'({1'b0, 10'd0, 10'd0, 24'h000000, 1'b1}));
    plan_pixel(32'h2468ACFF, 1, res_t'({1'b1, 10'd0, 10'd0, 24'h2468AC, 1'b0}));
    // Oversized registers clamp to the maximum, zero height acts as one
    plan_write(REG_IMAGE_WIDTH, 32'h7FF);
    plan_write(REG_IMAGE_HEIGHT, 32'h7FF);
    plan_write(REG_WINDOW_WIDTH, 32'h7FF);
    plan_write(REG_WINDOW_HEIGHT, 32'd0);
    plan_pixel(32'hFEDCBA98, 0, '0);
    plan_write(REG_IMAGE_HEIGHT, 32'd1);
    plan_write(REG_WINDOW_HEIGHT, 32'd1024);
    plan_pixel(32'h0F1E2D3C, 0, '0);
    plan_pixel(32'hF0E1D2C3, 0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_pixel(plan[i].pix, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: new settings, then a run of pixels that may stop mid-frame
    sent = 0;
    first = 1'b1;
    while (sent < RandomItems) begin
      settle();
      brisk = 1'b0;
      if (first || $urandom_range(0, 2) != 0) write_reg(REG_IMAGE_WIDTH, 32'(rand_size()));
      if (first || $urandom_range(0, 2) != 0) write_reg(REG_IMAGE_HEIGHT, 32'(rand_size()));
      if (first || $urandom_range(0, 2) != 0) write_reg(REG_WINDOW_WIDTH, 32'(rand_size()));
      if (first || $urandom_range(0, 2) != 0) write_reg(REG_WINDOW_HEIGHT, 32'(rand_size()));
      if (first || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_BACKGROUND, 32'h000000);
          1: write_reg(REG_BACKGROUND, 32'hFFFFFF);
          default: write_reg(REG_BACKGROUND, 32'($urandom_range(0, 24'hFFFFFF)));
        endcase
      end
      first = 1'b0;
      brisk = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 80);
      repeat (n) begin
        p = pix_t'($urandom);
        case ($urandom_range(0, 3))
          0: p.alpha_in = AlphaClear;
          1: p.alpha_in = AlphaOpaque;
          default: ;
        endcase
        send_pixel(p, 1'b0, '0);
      end
      sent += n;
    end

    brisk = 1'b0;
    settle();
    repeat (PipeDepth + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cbl_pkg.sv
hdl/cbl_cfg.sv
hdl/cbl_scan.sv
hdl/cbl_shade.sv
hdl/centered_alpha_blit_core.sv
hdl/cbl_checker.sv
dv/centered_alpha_blit_core_tb.sv
